// ----- sv/sbw_pkg.sv -----
// shared types, constants and helpers for the colour-keyed sprite blitter
// no dependencies; used by every module of the block by scoped names
package sbw_pkg;

    localparam int unsigned MAX_RESOLUTION_DEF = 2048;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned SIZE_W      = 12;
    localparam int unsigned NBYTES_W    = 3;
    localparam int unsigned PIX_W       = 16;
    localparam int unsigned OFF_W       = 24;
    localparam int unsigned BYTE_W      = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X        = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_KEY = 4'd7;

    // reset values
    localparam logic [COORD_W-1:0]  RST_ORIGIN_X        = 16'd0;
    localparam logic [COORD_W-1:0]  RST_ORIGIN_Y        = 16'd0;
    localparam logic [SIZE_W-1:0]   RST_SPRITE_WIDTH    = 12'd1;
    localparam logic [SIZE_W-1:0]   RST_SPRITE_HEIGHT   = 12'd1;
    localparam logic [SIZE_W-1:0]   RST_SCREEN_WIDTH    = 12'd1024;
    localparam logic [SIZE_W-1:0]   RST_SCREEN_HEIGHT   = 12'd768;
    localparam logic [NBYTES_W-1:0] RST_PIXEL_BYTES     = 3'd1;
    localparam logic [PIX_W-1:0]    RST_TRANSPARENT_KEY = 16'd0;

    localparam logic [NBYTES_W-1:0] NBYTES_MIN = 3'd1;
    localparam logic [NBYTES_W-1:0] NBYTES_MAX = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0]  origin_x;
        logic [COORD_W-1:0]  origin_y;
        logic [SIZE_W-1:0]   sprite_width;
        logic [SIZE_W-1:0]   sprite_height;
        logic [SIZE_W-1:0]   screen_width;
        logic [SIZE_W-1:0]   screen_height;
        logic [NBYTES_W-1:0] pixel_bytes;
        logic [PIX_W-1:0]    transparent_key;
    } cfg_t;

    typedef struct packed {
        logic accept;     // latch pixel and coordinates, step counters
        logic calc;       // row product and visibility
        logic load;       // first word into the output registers
        logic next_byte;  // current word taken, move to the next byte
    } dp_cmd_t;

    typedef struct packed {
        logic visible;
        logic last;
    } dp_status_t;

    function automatic logic [NBYTES_W-1:0] clamp_bytes(input logic [NBYTES_W-1:0] raw);
        logic [NBYTES_W-1:0] res;
        res = raw;
        if (raw < NBYTES_MIN) begin
            res = NBYTES_MIN;
        end else if (raw > NBYTES_MAX) begin
            res = NBYTES_MAX;
        end
        return res;
    endfunction

endpackage

// ----- sv/sprite_blit_color_key_writer_top.sv -----
// colour-keyed sprite blitter, frame-buffer byte writer
// a taken pixel passes the calc state, then the load state, before its first byte word is offered;
// a visible pixel then emits one byte word per pixel byte, holding while m_ready is low; a keyed or
//   clipped pixel returns to idle from calc; one pixel is in flight at a time
// reset: synchronous active-low aresetn clears counters and control, config to its defaults
// depends on sbw_pkg, sbw_regs, sbw_ctrl, sbw_dp
module sprite_blit_color_key_writer_top #(
    parameter int unsigned MAX_RESOLUTION = sbw_pkg::MAX_RESOLUTION_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sbw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sbw_pkg::PIX_W-1:0]          s_pixel_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sbw_pkg::OFF_W-1:0]          m_byte_offset,
    output logic [sbw_pkg::BYTE_W-1:0]         m_byte_data,
    output logic                               m_pixel_last
);

    sbw_pkg::cfg_t       cfg;
    sbw_pkg::dp_cmd_t    cmd;
    sbw_pkg::dp_status_t status;

    sbw_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sbw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .status  (status),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    sbw_dp #(
        .MAX_RESOLUTION (MAX_RESOLUTION)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .s_pixel_value (s_pixel_value),
        .status        (status),
        .m_byte_offset (m_byte_offset),
        .m_byte_data   (m_byte_data),
        .m_pixel_last  (m_pixel_last)
    );

endmodule

// ----- sv/sbw_regs.sv -----
// configuration register file of the sprite blitter
// depends on sbw_pkg
module sbw_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sbw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output sbw_pkg::cfg_t                      cfg
);

    sbw_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x        <= sbw_pkg::RST_ORIGIN_X;
            cfg_reg.origin_y        <= sbw_pkg::RST_ORIGIN_Y;
            cfg_reg.sprite_width    <= sbw_pkg::RST_SPRITE_WIDTH;
            cfg_reg.sprite_height   <= sbw_pkg::RST_SPRITE_HEIGHT;
            cfg_reg.screen_width    <= sbw_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height   <= sbw_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.pixel_bytes     <= sbw_pkg::RST_PIXEL_BYTES;
            cfg_reg.transparent_key <= sbw_pkg::RST_TRANSPARENT_KEY;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbw_pkg::REG_ORIGIN_X: begin
                    cfg_reg.origin_x <= cfg_wdata[sbw_pkg::COORD_W-1:0];
                end
                sbw_pkg::REG_ORIGIN_Y: begin
                    cfg_reg.origin_y <= cfg_wdata[sbw_pkg::COORD_W-1:0];
                end
                sbw_pkg::REG_SPRITE_WIDTH: begin
                    cfg_reg.sprite_width <= cfg_wdata[sbw_pkg::SIZE_W-1:0];
                end
                sbw_pkg::REG_SPRITE_HEIGHT: begin
                    cfg_reg.sprite_height <= cfg_wdata[sbw_pkg::SIZE_W-1:0];
                end
                sbw_pkg::REG_SCREEN_WIDTH: begin
                    cfg_reg.screen_width <= cfg_wdata[sbw_pkg::SIZE_W-1:0];
                end
                sbw_pkg::REG_SCREEN_HEIGHT: begin
                    cfg_reg.screen_height <= cfg_wdata[sbw_pkg::SIZE_W-1:0];
                end
                sbw_pkg::REG_PIXEL_BYTES: begin
                    cfg_reg.pixel_bytes <= cfg_wdata[sbw_pkg::NBYTES_W-1:0];
                end
                sbw_pkg::REG_TRANSPARENT_KEY: begin
                    cfg_reg.transparent_key <= cfg_wdata[sbw_pkg::PIX_W-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/sbw_ctrl.sv -----
// controller of the sprite blitter: sequences accept, calc, load and byte output
// depends on sbw_pkg
module sbw_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  m_ready,
    input  sbw_pkg::dp_status_t   status,
    output logic                  s_ready,
    output logic                  m_valid,
    output sbw_pkg::dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.accept   = 1'b1;
                    state_next   = ST_CALC;
                    s_ready_next = 1'b0;
                end
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                if (status.visible) begin
                    state_next = ST_LOAD;
                end else begin
                    // keyed out or clipped: nothing to write
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            ST_LOAD: begin
                cmd.load     = 1'b1;
                state_next   = ST_EMIT;
                m_valid_next = 1'b1;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (status.last) begin
                        state_next   = ST_IDLE;
                        m_valid_next = 1'b0;
                        s_ready_next = 1'b1;
                    end else begin
                        cmd.next_byte = 1'b1;
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_ready_valid_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready_reg && m_valid_reg))
        else $error("input ready while a word is offered");

    a_accept_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !s_ready_reg)
        else $error("input still open after a pixel was taken");

    a_hidden_pixel_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.calc && !status.visible) |=> (s_ready_reg && !m_valid_reg))
        else $error("hidden pixel did not return to idle");

    a_load_offers_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid_reg)
        else $error("loaded word not offered");
`endif

endmodule

// ----- sv/sbw_dp.sv -----
// datapath of the sprite blitter: sprite counters, coordinate and offset
// arithmetic, output word registers; depends on sbw_pkg
module sbw_dp #(
    parameter int unsigned MAX_RESOLUTION = sbw_pkg::MAX_RESOLUTION_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sbw_pkg::cfg_t                   cfg,
    input  sbw_pkg::dp_cmd_t                cmd,
    input  logic [sbw_pkg::PIX_W-1:0]       s_pixel_value,
    output sbw_pkg::dp_status_t             status,
    output logic [sbw_pkg::OFF_W-1:0]       m_byte_offset,
    output logic [sbw_pkg::BYTE_W-1:0]      m_byte_data,
    output logic                            m_pixel_last
);

    localparam int unsigned CW  = $clog2(MAX_RESOLUTION);
    localparam int unsigned SW  = $clog2(MAX_RESOLUTION + 1);
    localparam int unsigned MW  = CW + SW;
    localparam int unsigned OW  = sbw_pkg::OFF_W;
    localparam int unsigned XW  = sbw_pkg::COORD_W;
    localparam int unsigned NW  = sbw_pkg::NBYTES_W;
    localparam int unsigned BW  = sbw_pkg::BYTE_W;
    localparam logic [sbw_pkg::SIZE_W:0] MAX_EXT = (sbw_pkg::SIZE_W + 1)'(MAX_RESOLUTION);
    localparam logic [SW-1:0]            MAX_SZ  = SW'(MAX_RESOLUTION);

    // effective sizes
    logic [SW-1:0] spr_w, spr_h, scr_w, scr_h;
    logic [NW-1:0] nb;

    always_comb begin
        if ({1'b0, cfg.sprite_width} > MAX_EXT) begin
            spr_w = MAX_SZ;
        end else if (cfg.sprite_width == '0) begin
            spr_w = SW'(1);
        end else begin
            spr_w = SW'(cfg.sprite_width);
        end
        if ({1'b0, cfg.sprite_height} > MAX_EXT) begin
            spr_h = MAX_SZ;
        end else if (cfg.sprite_height == '0) begin
            spr_h = SW'(1);
        end else begin
            spr_h = SW'(cfg.sprite_height);
        end
        scr_w = ({1'b0, cfg.screen_width} > MAX_EXT) ? MAX_SZ : SW'(cfg.screen_width);
        scr_h = ({1'b0, cfg.screen_height} > MAX_EXT) ? MAX_SZ : SW'(cfg.screen_height);
        nb    = sbw_pkg::clamp_bytes(cfg.pixel_bytes);
    end

    // sprite counters
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [SW:0]   col_inc, row_inc;

    always_comb begin
        col_inc  = (SW + 1)'(col_reg) + (SW + 1)'(1);
        row_inc  = (SW + 1)'(row_reg) + (SW + 1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= {1'b0, spr_w}) begin
            // also catches a counter left beyond a shrunk size
            col_next = '0;
            row_next = (row_inc >= {1'b0, spr_h}) ? '0 : CW'(row_inc);
        end else begin
            col_next = CW'(col_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // pixel pipeline registers
    logic [sbw_pkg::PIX_W-1:0] pix_reg;
    logic [XW-1:0]             x_reg, y_reg;
    logic [OW-1:0]             prod_reg, prod_next;
    logic [MW-1:0]             mul_full;
    logic [OW-1:0]             sum, scaled;

    assign mul_full  = MW'(y_reg[CW-1:0]) * MW'(scr_w);
    assign prod_next = OW'(mul_full);

    assign status.visible = (pix_reg != cfg.transparent_key)
                         && (x_reg < XW'(scr_w))
                         && (y_reg < XW'(scr_h));

    // offset times bytes per pixel, nb is one of 1..4
    always_comb begin
        sum    = prod_reg + OW'(x_reg[CW-1:0]);
        scaled = (nb[0] ? sum : '0)
               + (nb[1] ? (sum << 1) : '0)
               + (nb[2] ? (sum << 2) : '0);
    end

    // output word registers
    logic [OW-1:0] out_offset_reg;
    logic [BW-1:0] out_data_reg;
    logic          out_last_reg;
    logic [1:0]    idx_reg;
    logic [NW-1:0] idx_plus2;

    assign idx_plus2 = NW'(idx_reg) + NW'(2);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= s_pixel_value;
            x_reg   <= cfg.origin_x + XW'(col_reg);
            y_reg   <= cfg.origin_y + XW'(row_reg);
        end
        if (cmd.calc) begin
            prod_reg <= prod_next;
        end
        if (cmd.load) begin
            out_offset_reg <= scaled;
            out_data_reg   <= pix_reg[BW-1:0];
            out_last_reg   <= (nb == NW'(1));
            idx_reg        <= '0;
        end else if (cmd.next_byte) begin
            out_offset_reg <= out_offset_reg + OW'(1);
            // high byte after the low one, zero above bit 15
            out_data_reg   <= (idx_reg == 2'd0) ? pix_reg[2*BW-1:BW] : '0;
            out_last_reg   <= (idx_plus2 == nb);
            idx_reg        <= idx_reg + 2'd1;
        end
    end

    assign status.last   = out_last_reg;
    assign m_byte_offset = out_offset_reg;
    assign m_byte_data   = out_data_reg;
    assign m_pixel_last  = out_last_reg;

`ifndef SYNTHESIS
    a_offset_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.next_byte |=> (out_offset_reg == $past(out_offset_reg) + OW'(1)))
        else $error("byte offset did not step by one");

    a_single_byte_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && nb == NW'(1)) |=> out_last_reg)
        else $error("single-byte pixel not marked last");

    a_counter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (SW + 1)'(col_reg) < (SW + 1)'(MAX_RESOLUTION)
        && (SW + 1)'(row_reg) < (SW + 1)'(MAX_RESOLUTION))
        else $error("sprite counter beyond maximum resolution");
`endif

endmodule

// ----- sim/sprite_blit_color_key_writer_top_tb.sv -----
// self-checking testbench for sprite_blit_color_key_writer_top: predicts every frame-buffer
// byte write from the accepted pixels and compares it with the block's output words
// depends on sbw_pkg and the block's rtl; reads no files
`timescale 1ns / 1ps

module sprite_blit_color_key_writer_top_tb;

    localparam int unsigned        MAX_RES        = sbw_pkg::MAX_RESOLUTION_DEF;
    localparam int                 LAT_PAUSE      = 8;
    localparam int                 HOLD_CYCLES    = 300;
    localparam logic [sbw_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [sbw_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 4'd15;
    // sprite straddling the 16-bit wrap of both origins
    localparam logic [sbw_pkg::PIX_W-1:0] WRAP_PIX [11] = '{
        16'hFFFF, 16'h1234, 16'h0000, 16'h8001, 16'h5A5A, 16'hFFFF,
        16'h00FF, 16'hFF00, 16'h7FFF, 16'hFFFE, 16'h0001
    };

    typedef struct {
        logic [sbw_pkg::OFF_W-1:0]  offset;
        logic [sbw_pkg::BYTE_W-1:0] data;
        logic                       pix_last;
    } fb_write_t;

    class fb_write_tracker;
        sbw_pkg::cfg_t cfg;
        int unsigned   col_pos;
        int unsigned   row_pos;
        fb_write_t     due_writes[$];
        int            error_count;

        function new();
            cfg.origin_x        = sbw_pkg::RST_ORIGIN_X;
            cfg.origin_y        = sbw_pkg::RST_ORIGIN_Y;
            cfg.sprite_width    = sbw_pkg::RST_SPRITE_WIDTH;
            cfg.sprite_height   = sbw_pkg::RST_SPRITE_HEIGHT;
            cfg.screen_width    = sbw_pkg::RST_SCREEN_WIDTH;
            cfg.screen_height   = sbw_pkg::RST_SCREEN_HEIGHT;
            cfg.pixel_bytes     = sbw_pkg::RST_PIXEL_BYTES;
            cfg.transparent_key = sbw_pkg::RST_TRANSPARENT_KEY;
            col_pos     = 0;
            row_pos     = 0;
            error_count = 0;
        endfunction

        function int pending();
            return due_writes.size();
        endfunction

        function int unsigned cap_res(input int unsigned v);
            return (v > MAX_RES) ? MAX_RES : v;
        endfunction

        task flag_error(input string what);
            if (error_count < 100) begin
                $display("%0t: %s", $time, what);
            end
            error_count++;
        endtask

        function void write_reg(input logic [sbw_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [sbw_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sbw_pkg::REG_ORIGIN_X:        cfg.origin_x        = val;
                sbw_pkg::REG_ORIGIN_Y:        cfg.origin_y        = val;
                sbw_pkg::REG_SPRITE_WIDTH:    cfg.sprite_width    = val[sbw_pkg::SIZE_W-1:0];
                sbw_pkg::REG_SPRITE_HEIGHT:   cfg.sprite_height   = val[sbw_pkg::SIZE_W-1:0];
                sbw_pkg::REG_SCREEN_WIDTH:    cfg.screen_width    = val[sbw_pkg::SIZE_W-1:0];
                sbw_pkg::REG_SCREEN_HEIGHT:   cfg.screen_height   = val[sbw_pkg::SIZE_W-1:0];
                sbw_pkg::REG_PIXEL_BYTES:     cfg.pixel_bytes     = val[sbw_pkg::NBYTES_W-1:0];
                sbw_pkg::REG_TRANSPARENT_KEY: cfg.transparent_key = val;
                default: ;
            endcase
        endfunction

        function void take_pixel(input logic [sbw_pkg::PIX_W-1:0] pix);
            logic [sbw_pkg::COORD_W-1:0] x_pos;
            logic [sbw_pkg::COORD_W-1:0] y_pos;
            int unsigned                 scr_w;
            int unsigned                 scr_h;
            int unsigned                 spr_w;
            int unsigned                 spr_h;
            int unsigned                 nbytes;
            int unsigned                 base;
            fb_write_t                   w;
            x_pos = cfg.origin_x + 16'(col_pos);
            y_pos = cfg.origin_y + 16'(row_pos);
            scr_w = cap_res(cfg.screen_width);
            scr_h = cap_res(cfg.screen_height);
            spr_w = cap_res((cfg.sprite_width == 0) ? 1 : cfg.sprite_width);
            spr_h = cap_res((cfg.sprite_height == 0) ? 1 : cfg.sprite_height);

            // counters step on every pixel, keyed and clipped ones too
            if (col_pos + 1 >= spr_w) begin
                col_pos = 0;
                if (row_pos + 1 >= spr_h) begin
                    row_pos = 0;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end

            if (pix == cfg.transparent_key) return;
            if (x_pos >= scr_w || y_pos >= scr_h) return;

            nbytes = cfg.pixel_bytes;
            if (nbytes == 0) nbytes = 1;
            if (nbytes > 4) nbytes = 4;

            base = (y_pos * scr_w + x_pos) * nbytes;
            for (int i = 0; i < nbytes; i++) begin
                w.offset   = 24'(base + i);
                w.data     = (i < 2) ? pix[8*i +: 8] : 8'h00;
                w.pix_last = (i + 1 == nbytes);
                due_writes.push_back(w);
            end
        endfunction

        task take_write(input logic [sbw_pkg::OFF_W-1:0] off,
                        input logic [sbw_pkg::BYTE_W-1:0] dat,
                        input logic lst);
            fb_write_t w;
            if (due_writes.size() == 0) begin
                flag_error($sformatf("unexpected byte write offset=%h data=%h last=%b",
                                     off, dat, lst));
            end else begin
                w = due_writes.pop_front();
                if (off !== w.offset)
                    flag_error($sformatf("byte_offset %h, want %h", off, w.offset));
                if (dat !== w.data)
                    flag_error($sformatf("byte_data %h at %h, want %h", dat, w.offset,
                                         w.data));
                if (lst !== w.pix_last)
                    flag_error($sformatf("pixel_last %b at %h, want %b", lst, w.offset,
                                         w.pix_last));
            end
        endtask

        task final_check();
            if (due_writes.size() != 0)
                flag_error($sformatf("%0d byte writes never arrived", due_writes.size()));
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [sbw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sbw_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [sbw_pkg::PIX_W-1:0]       s_pixel_value;
    logic                            m_valid;
    logic                            m_ready;
    logic [sbw_pkg::OFF_W-1:0]       m_byte_offset;
    logic [sbw_pkg::BYTE_W-1:0]      m_byte_data;
    logic                            m_pixel_last;

    bit tx_quiet;
    bit rx_quiet;
    bit hold_req;

    fb_write_tracker model = new();

    sprite_blit_color_key_writer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_offset (m_byte_offset),
        .m_byte_data   (m_byte_data),
        .m_pixel_last  (m_pixel_last)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: per-word stall draws, plus one long hold-off on request
    initial begin : byte_sink
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                model.take_write(m_byte_offset, m_byte_data, m_pixel_last);
                stall = rx_quiet ? 0 : $urandom_range(0, 16);
            end
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic int tx_gap();
        return tx_quiet ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_pixel(input logic [sbw_pkg::PIX_W-1:0] pix, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model.take_pixel(pix);
    endtask

    // drop valid, wait for every due word, then let a keyed pixel finish
    task automatic settle(input int extra);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (model.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sbw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sbw_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        model.write_reg(idx, val);
    endtask

    function automatic logic [sbw_pkg::CFG_DATA_W-1:0] pick_size();
        logic [sbw_pkg::SIZE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 12'd0;
            1:       v = 12'd2048;
            2:       v = 12'd4095;
            3:       v = 12'd2047;
            default: v = 12'($urandom_range(1, 6));
        endcase
        return {4'($urandom), v};
    endfunction

    function automatic logic [sbw_pkg::CFG_DATA_W-1:0] pick_screen();
        logic [sbw_pkg::SIZE_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = 12'd0;
            1:       v = 12'd1;
            2:       v = 12'd2048;
            3:       v = 12'd4095;
            4, 5:    v = 12'($urandom_range(1, 4095));
            default: v = 12'($urandom_range(16, 1024));
        endcase
        return {4'($urandom), v};
    endfunction

    function automatic logic [sbw_pkg::CFG_DATA_W-1:0] pick_origin(
        input logic [sbw_pkg::SIZE_W-1:0] edge_at);
        case ($urandom_range(0, 7))
            0:       return 16'($urandom_range(65530, 65535));
            1:       return 16'($urandom);
            2:       return 16'(edge_at) - 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, 24));
        endcase
    endfunction

    task automatic shuffle_config(input bit all_regs);
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_SPRITE_WIDTH, pick_size());
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_SPRITE_HEIGHT, pick_size());
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_SCREEN_WIDTH, pick_screen());
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_SCREEN_HEIGHT, pick_screen());
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_ORIGIN_X, pick_origin(model.cfg.screen_width));
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_ORIGIN_Y, pick_origin(model.cfg.screen_height));
        if (all_regs || $urandom_range(0, 1))
            write_reg(sbw_pkg::REG_PIXEL_BYTES, {13'($urandom), 3'($urandom_range(0, 7))});
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0:       write_reg(sbw_pkg::REG_TRANSPARENT_KEY, 16'h0000);
                1:       write_reg(sbw_pkg::REG_TRANSPARENT_KEY, 16'hFFFF);
                default: write_reg(sbw_pkg::REG_TRANSPARENT_KEY, 16'($urandom));
            endcase
        end
        // unmapped indexes must leave everything alone
        if ($urandom_range(0, 3) == 0)
            write_reg(4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
    endtask

    function automatic logic [sbw_pkg::PIX_W-1:0] next_pixel();
        case ($urandom_range(0, 7))
            0, 1:    return model.cfg.transparent_key;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int n;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_pixel_value = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_req      = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: unit sprite at the corner, key 0, one byte per pixel
        send_pixel(16'h0000, tx_gap());
        send_pixel(16'hFFFF, tx_gap());
        send_pixel(16'h00A5, tx_gap());
        settle(LAT_PAUSE);

        // origins wrap, oversized screen, pixel_bytes above 4, key 0xffff
        write_reg(sbw_pkg::REG_ORIGIN_X, 16'hFFFE);
        write_reg(sbw_pkg::REG_ORIGIN_Y, 16'hFFFF);
        write_reg(sbw_pkg::REG_SPRITE_WIDTH, 16'd4);
        write_reg(sbw_pkg::REG_SPRITE_HEIGHT, 16'd3);
        write_reg(sbw_pkg::REG_SCREEN_WIDTH, 16'h0FFF);
        write_reg(sbw_pkg::REG_SCREEN_HEIGHT, 16'hFFFF);
        write_reg(sbw_pkg::REG_PIXEL_BYTES, 16'h0007);
        write_reg(sbw_pkg::REG_TRANSPARENT_KEY, 16'hFFFF);
        for (int k = 0; k < 11; k++) send_pixel(WRAP_PIX[k], tx_gap());
        settle(LAT_PAUSE);

        // zero screen width clips everything
        write_reg(sbw_pkg::REG_ORIGIN_X, 16'h0000);
        write_reg(sbw_pkg::REG_ORIGIN_Y, 16'h0000);
        write_reg(sbw_pkg::REG_SCREEN_WIDTH, 16'h0000);
        send_pixel(16'h4321, tx_gap());
        send_pixel(16'h0000, tx_gap());
        send_pixel(16'hA5A5, tx_gap());
        settle(LAT_PAUSE);

        // far corner of the largest screen; counters sit past the shrunk sprite
        write_reg(sbw_pkg::REG_SCREEN_WIDTH, 16'd2048);
        write_reg(sbw_pkg::REG_SCREEN_HEIGHT, 16'd2048);
        write_reg(sbw_pkg::REG_ORIGIN_X, 16'd2047);
        write_reg(sbw_pkg::REG_ORIGIN_Y, 16'd2047);
        write_reg(sbw_pkg::REG_SPRITE_WIDTH, 16'd1);
        write_reg(sbw_pkg::REG_SPRITE_HEIGHT, 16'd1);
        write_reg(sbw_pkg::REG_PIXEL_BYTES, 16'd4);
        send_pixel(16'hBEEF, tx_gap());
        send_pixel(16'h0102, tx_gap());
        send_pixel(16'h8080, tx_gap());
        settle(LAT_PAUSE);

        // zero sprite size and zero pixel_bytes
        write_reg(sbw_pkg::REG_SPRITE_WIDTH, 16'hF000);
        write_reg(sbw_pkg::REG_SPRITE_HEIGHT, 16'h0000);
        write_reg(sbw_pkg::REG_PIXEL_BYTES, 16'hFFF8);
        write_reg(sbw_pkg::REG_ORIGIN_X, 16'd5);
        write_reg(sbw_pkg::REG_ORIGIN_Y, 16'd9);
        send_pixel(16'hFFFF, tx_gap());
        send_pixel(16'h00C3, tx_gap());
        send_pixel(16'hFF3C, tx_gap());
        settle(LAT_PAUSE);

        for (int phase = 0; phase < 11; phase++) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 4) begin
                // on-screen 4-byte pixels, some keyed, while the receiver holds off
                write_reg(sbw_pkg::REG_ORIGIN_X, 16'd3);
                write_reg(sbw_pkg::REG_ORIGIN_Y, 16'd2);
                write_reg(sbw_pkg::REG_SPRITE_WIDTH, 16'd3);
                write_reg(sbw_pkg::REG_SPRITE_HEIGHT, 16'd2);
                write_reg(sbw_pkg::REG_SCREEN_WIDTH, 16'd1024);
                write_reg(sbw_pkg::REG_SCREEN_HEIGHT, 16'd768);
                write_reg(sbw_pkg::REG_PIXEL_BYTES, 16'd4);
                write_reg(sbw_pkg::REG_TRANSPARENT_KEY, 16'($urandom));
                tx_quiet = 1'b1;
                rx_quiet = 1'b0;
                hold_req = 1'b1;
            end else begin
                shuffle_config(phase == 0);
            end
            n = $urandom_range(12, 26);
            for (int k = 0; k < n; k++) begin
                send_pixel(next_pixel(), tx_gap());
                if ($urandom_range(0, 39) == 0) settle(0);
            end
            settle(LAT_PAUSE);
        end

        settle(4 * LAT_PAUSE);
        model.final_check();
        if (model.error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
